// ===== hdl/apq_pkg.sv =====
package apq_pkg;

  // Store geometry
  localparam int unsigned Capacity = 8;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;

  // Operation codes
  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One stored entry
  typedef struct packed {
    logic signed [DataW-1:0] pri;
    logic signed [DataW-1:0] val;
  } entry_t;

  // True when entry a ranks strictly above entry b: higher priority, then larger value
  function automatic logic ranks_above(
    input logic signed [DataW-1:0] a_pri,
    input logic signed [DataW-1:0] a_val,
    input logic signed [DataW-1:0] b_pri,
    input logic signed [DataW-1:0] b_val
  );
    return (a_pri > b_pri) || ((a_pri == b_pri) && (a_val > b_val));
  endfunction

endpackage

// ===== hdl/apq_ram.sv =====
module apq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write one word, read one word with registered data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/array_priority_queue_unit.sv =====
// Bounded priority queue of eight entries kept in arrival order.
// Command channel: drive func_i, item_value_i and item_priority_i and raise
// start; the word is taken at a rising edge where start is high and busy is
// low. Push (FUNC_PUSH) appends an entry, pop (FUNC_POP) removes the entry of
// highest priority (larger value, then earlier slot, breaks ties).
// Result channel: done_o is high for exactly one cycle and carries status_o,
// entry_count_o and the top entry after the operation; the receiver must
// take it in that cycle, as it cannot hold results off.
// Latency: a push, a pop on an empty queue and a pop that empties the queue
// answer in the cycle after acceptance and leave busy low, so a new word may
// follow at once. Any other pop shifts any later entries down one slot per
// cycle through the entry RAM, then rescans the held entries one RAM read per
// cycle for the new top, with busy high for all cycles before the result.
// The single-port-read entry RAM sets both loops.
// Reset clears the count and the sequencer; the queue is then empty and the
// RAM contents are never read before they are written.
module array_priority_queue_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic                                func_i,
  input  logic signed [apq_pkg::DataW-1:0]    item_value_i,
  input  logic signed [apq_pkg::DataW-1:0]    item_priority_i,
  output logic                                done_o,
  output logic [1:0]                          status_o,
  output logic [3:0]                          entry_count_o,
  output logic                                top_valid_o,
  output logic signed [apq_pkg::DataW-1:0]    top_value_o,
  output logic signed [apq_pkg::DataW-1:0]    top_priority_o
);
  import apq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_SCAN  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     top_idx_q, top_idx_d;
  logic signed [DataW-1:0] top_val_q, top_val_d;
  logic signed [DataW-1:0] top_pri_q, top_pri_d;
  logic [IdxW-1:0]     ptr_q, ptr_d;
  logic [CntW-1:0]     rd_q, rd_d;
  logic                rv_q, rv_d;
  logic [IdxW-1:0]     ci_q, ci_d;
  logic                done_q, done_d;
  status_e             status_q, status_d;

  logic                accept;
  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  entry_t              ram_wdata;
  logic [IdxW-1:0]     ram_raddr;
  entry_t              ram_rdata;
  logic [CntW-1:0]     count_dec;

  assign accept    = start && (state_q == S_IDLE);
  assign count_dec = count_q - CntW'(1);

  apq_ram #(
    .Width($bits(entry_t)),
    .Depth(Capacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Sequence push, shift-down and top rescan
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    top_idx_d = top_idx_q;
    top_val_d = top_val_q;
    top_pri_d = top_pri_q;
    ptr_d     = ptr_q;
    rd_d      = rd_q;
    rv_d      = 1'b0;
    ci_d      = ci_q;
    done_d    = 1'b0;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ram_rdata;
    ram_raddr = IdxW'(CntW'(top_idx_q) + CntW'(1));

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (func_e'(func_i) == FUNC_PUSH) begin
            done_d = 1'b1;
            if (count_q >= CntW'(Capacity)) begin
              // drop the word, queue unchanged
              status_d = ST_FULL;
            end else begin
              // append and fold the new entry into the cached top
              status_d      = ST_DONE;
              ram_we        = 1'b1;
              ram_waddr     = count_q[IdxW-1:0];
              ram_wdata.pri = item_priority_i;
              ram_wdata.val = item_value_i;
              count_d       = count_q + CntW'(1);
              if ((count_q == '0) ||
                  ranks_above(item_priority_i, item_value_i, top_pri_q, top_val_q)) begin
                top_idx_d = count_q[IdxW-1:0];
                top_pri_d = item_priority_i;
                top_val_d = item_value_i;
              end
            end
          end else begin
            if (count_q == '0) begin
              done_d   = 1'b1;
              status_d = ST_EMPTY;
            end else begin
              status_d = ST_DONE;
              count_d  = count_dec;
              if (count_dec == '0) begin
                done_d = 1'b1;
              end else if (CntW'(top_idx_q) < count_dec) begin
                // read of the slot after the top is already under way
                state_d = S_SHIFT;
                ptr_d   = top_idx_q;
              end else begin
                state_d = S_SCAN;
                rd_d    = '0;
              end
            end
          end
        end
      end
      S_SHIFT: begin
        // move one entry down a slot per cycle
        ram_we    = 1'b1;
        ram_waddr = ptr_q;
        ram_wdata = ram_rdata;
        ram_raddr = IdxW'(CntW'(ptr_q) + CntW'(2));
        if ((CntW'(ptr_q) + CntW'(1)) < count_q) begin
          ptr_d = ptr_q + IdxW'(1);
        end else begin
          state_d = S_SCAN;
          rd_d    = '0;
        end
      end
      S_SCAN: begin
        // issue one read per cycle, compare the word that returns
        ram_raddr = rd_q[IdxW-1:0];
        if (rd_q < count_q) begin
          rv_d = 1'b1;
          ci_d = rd_q[IdxW-1:0];
          rd_d = rd_q + CntW'(1);
        end
        if (rv_q) begin
          if ((ci_q == '0) ||
              ranks_above(ram_rdata.pri, ram_rdata.val, top_pri_q, top_val_q)) begin
            top_idx_d = ci_q;
            top_pri_d = ram_rdata.pri;
            top_val_d = ram_rdata.val;
          end
          if ((CntW'(ci_q) + CntW'(1)) == count_q) begin
            state_d = S_IDLE;
            done_d  = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      rv_q     <= 1'b0;
      done_q   <= 1'b0;
      status_q <= ST_DONE;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rv_q     <= rv_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  // Hold top entry and sequencer pointers
  always_ff @(posedge clk_i) begin
    top_idx_q <= top_idx_d;
    top_val_q <= top_val_d;
    top_pri_q <= top_pri_d;
    ptr_q     <= ptr_d;
    rd_q      <= rd_d;
    ci_q      <= ci_d;
  end

  // Drive result word
  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign entry_count_o  = 4'(count_q);
  assign top_valid_o    = (count_q != '0);
  assign top_value_o    = top_valid_o ? top_val_q : '0;
  assign top_priority_o = top_valid_o ? top_pri_q : '0;

  // Checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result issued while sequencer busy");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == ST_FULL)) |-> (count_q == CntW'(Capacity)))
    else $error("push dropped while store not full");

  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == ST_EMPTY)) |-> (count_q == '0))
    else $error("empty pop reported with entries held");

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (CntW'(ptr_q) < count_q))
    else $error("shift writes beyond held entries");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rv_q |-> ((state_q == S_SCAN) && (CntW'(ci_q) < count_q)))
    else $error("scan compares an entry that is not held");

endmodule
